FILE: hw/rtl/chtl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtl_pkg
// Shared types and codes for the chained hash table lookup/insert block.
// ----------------------------------------------------------------------------
package chtl_pkg;

    localparam int KEY_W    = 32;
    localparam int OUT_IDX_W = 12;

    // Operation codes
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [2:0] STS_FOUND     = 3'd0;
    localparam logic [2:0] STS_ABSENT    = 3'd1;
    localparam logic [2:0] STS_INSERTED  = 3'd2;
    localparam logic [2:0] STS_DUPLICATE = 3'd3;
    localparam logic [2:0] STS_OVERFLOW  = 3'd4;
    localparam logic [2:0] STS_CLEARED   = 3'd5;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [KEY_W-1:0] key;
    } in_word_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [OUT_IDX_W-1:0] entry_index;
        logic [OUT_IDX_W-1:0] bucket;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_HEAD_RD,
        ST_HEAD_CHK,
        ST_ENT_CHK,
        ST_COMMIT,
        ST_RESP,
        ST_INIT
    } chtl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic sweep;
        logic load;
        logic head_chk;
        logic ent_chk;
        logic commit;
        logic out_load;
    } chtl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic sweep_done;
        logic in_clear;
        logic hash_done;
        logic head_empty;
        logic walk_done;
        logic out_free;
    } chtl_stat_t;

endpackage

FILE: hw/rtl/chained_hash_table_lookup_insert.sv
`timescale 1ns / 1ps
// Flow: lookup and insert hash the key, read the bucket head and walk the chain, one
//   entry read per cycle, before the commit; clear goes straight to the commit.
// One item at a time: another is accepted only once the last result word is loaded
//   into the output register; the key remainder unit runs a quotient and a remainder step.
// Reset (aresetn low, synchronous): empties the table; after release the head memory is
//   zeroed by a sweep of all TABLE_SIZE buckets, with the input not ready until it ends.
// ----------------------------------------------------------------------------
// chained_hash_table_lookup_insert
// Chained hash table with lookup, insert and clear of 32-bit keys.
// ----------------------------------------------------------------------------
module chained_hash_table_lookup_insert #(
    parameter int TABLE_SIZE = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  chtl_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output chtl_pkg::out_word_t m_data
);
    import chtl_pkg::*;

    chtl_cmd_t  cmd;
    chtl_stat_t stat;

    chtl_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    chtl_datapath #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data),
        .cmd    (cmd),
        .stat   (stat)
    );

endmodule

FILE: hw/rtl/chtl_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtl_mod_unit
// Remainder of a 32-bit key by TABLE_SIZE-1 through a reciprocal multiply,
// with the quotient registered first and the remainder in the next cycle.
// ----------------------------------------------------------------------------
module chtl_mod_unit #(
    parameter int TABLE_SIZE = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [chtl_pkg::KEY_W-1:0]    key,
    output logic                          done,
    output logic [$clog2(TABLE_SIZE)-1:0] rem
);
    import chtl_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int SHIFT  = KEY_W + $clog2(TABLE_SIZE - 1);
    localparam int PROD_W = SHIFT + KEY_W;
    // Rounded-up reciprocal; exact floor quotient for every 32-bit key
    localparam logic [KEY_W:0] RECIP = (KEY_W+1)'(
        ((64'd1 << SHIFT) + 64'(TABLE_SIZE - 2)) / 64'(TABLE_SIZE - 1));
    localparam logic [KEY_W-1:0] DIVISOR = KEY_W'(TABLE_SIZE - 1);

    logic [KEY_W-1:0]  key_reg, key_next;
    logic [KEY_W-1:0]  quot_reg, quot_next;
    logic [IDX_W-1:0]  rem_reg, rem_next;
    logic              mul_reg, mul_next;
    logic              sub_reg, sub_next;
    logic              done_reg, done_next;
    logic [PROD_W-1:0] prod;
    logic [KEY_W-1:0]  diff;

    // Quotient by the reciprocal, remainder by subtracting quotient times divisor
    assign prod = PROD_W'(key_reg) * PROD_W'(RECIP);
    assign diff = key_reg - quot_reg * DIVISOR;

    // Advance the key through the two steps
    always_comb begin
        key_next  = key_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        mul_next  = 1'b0;
        sub_next  = 1'b0;
        done_next = 1'b0;
        if (start) begin
            key_next = key;
            mul_next = 1'b1;
        end else if (mul_reg) begin
            quot_next = prod[PROD_W-1:SHIFT];
            sub_next  = 1'b1;
        end else if (sub_reg) begin
            rem_next  = diff[IDX_W-1:0];
            done_next = 1'b1;
        end
    end

    // Hold control under reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_reg  <= 1'b0;
            sub_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            mul_reg  <= mul_next;
            sub_reg  <= sub_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

FILE: hw/rtl/chtl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtl_datapath
// Table memories, chain walk registers, result formation and output word.
// ----------------------------------------------------------------------------
module chtl_datapath #(
    parameter int TABLE_SIZE = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  chtl_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output chtl_pkg::out_word_t  m_data,
    input  chtl_pkg::chtl_cmd_t  cmd,
    output chtl_pkg::chtl_stat_t stat
);
    import chtl_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam logic [IDX_W:0] SIZE_EXT = (IDX_W+1)'(TABLE_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    // Memories. A head is trusted only if it points at a live entry of its
    // own bucket, so a table clear needs no sweep of the head memory; the
    // head memory is zeroed once after reset.
    logic [IDX_W-1:0] heads_mem [TABLE_SIZE];
    logic [IDX_W-1:0] link_mem  [TABLE_SIZE];
    logic [KEY_W-1:0] key_mem   [TABLE_SIZE];
    logic [IDX_W-1:0] ebkt_mem  [TABLE_SIZE];

    logic [IDX_W-1:0] heads_rd_reg;
    logic [IDX_W-1:0] link_rd_reg;
    logic [KEY_W-1:0] key_rd_reg;
    logic [IDX_W-1:0] ebkt_rd_reg;

    logic [1:0]       op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [IDX_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] cur_reg;
    logic [IDX_W-1:0] vhead_reg;
    logic [IDX_W-1:0] hit_reg;
    logic             first_reg;
    logic [IDX_W-1:0] sweep_reg;
    out_word_t        res_reg, res_next;
    logic             m_valid_reg;
    out_word_t        m_data_reg;

    logic             hash_done;
    logic [IDX_W-1:0] rem;
    logic [IDX_W-1:0] bucket_w;
    logic [IDX_W-1:0] ent_ra;
    logic             first_bad;
    logic             key_match;
    logic [IDX_W:0]   n_ext;
    logic [IDX_W-1:0] n_idx;
    logic             ins_we;
    logic             head_we;
    logic [IDX_W-1:0] head_wa;
    logic [IDX_W-1:0] head_wd;

    chtl_mod_unit #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_mod (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cmd.load),
        .key    (s_data.key),
        .done   (hash_done),
        .rem    (rem)
    );

    assign bucket_w = rem + IDX_W'(1);

    // Chain walk decode
    assign ent_ra    = cmd.head_chk ? heads_rd_reg : link_rd_reg;
    assign first_bad = first_reg && (ebkt_rd_reg != bucket_w);
    assign key_match = !first_bad && (key_rd_reg == key_reg);
    assign n_ext     = {1'b0, count_reg} + (IDX_W+1)'(1);
    assign n_idx     = n_ext[IDX_W-1:0];

    assign stat.sweep_done = (sweep_reg == LAST_IDX);
    assign stat.in_clear   = (s_data.opcode == OP_CLEAR);
    assign stat.hash_done  = hash_done;
    assign stat.head_empty = (heads_rd_reg == '0) || (heads_rd_reg > count_reg);
    assign stat.walk_done  = first_bad || key_match || (link_rd_reg == '0);
    assign stat.out_free   = !m_valid_reg || m_ready;

    // Form the result and the table update
    always_comb begin
        res_next   = res_reg;
        count_next = count_reg;
        ins_we     = 1'b0;
        if (cmd.commit) begin
            if (op_reg == OP_CLEAR) begin
                count_next = '0;
                res_next   = '{STS_CLEARED, '0, '0};
            end else if (op_reg == OP_INSERT) begin
                if (hit_reg != '0) begin
                    res_next = '{STS_DUPLICATE, OUT_IDX_W'(hit_reg), OUT_IDX_W'(bucket_w)};
                end else if (n_ext >= SIZE_EXT) begin
                    count_next = '0;
                    res_next   = '{STS_OVERFLOW, '0, OUT_IDX_W'(bucket_w)};
                end else begin
                    count_next = n_idx;
                    ins_we     = 1'b1;
                    res_next   = '{STS_INSERTED, OUT_IDX_W'(n_idx), OUT_IDX_W'(bucket_w)};
                end
            end else if (hit_reg != '0) begin
                res_next = '{STS_FOUND, OUT_IDX_W'(hit_reg), OUT_IDX_W'(bucket_w)};
            end else begin
                res_next = '{STS_ABSENT, '0, OUT_IDX_W'(bucket_w)};
            end
        end
    end

    // Head write port: zero sweep after reset, else new entry at its bucket
    assign head_we = ins_we || cmd.sweep;
    assign head_wa = cmd.sweep ? sweep_reg : bucket_w;
    assign head_wd = cmd.sweep ? '0 : n_idx;

    // Head memory
    always_ff @(posedge aclk) begin
        if (head_we) begin
            heads_mem[head_wa] <= head_wd;
        end
        heads_rd_reg <= heads_mem[bucket_w];
    end

    // Entry memories
    always_ff @(posedge aclk) begin
        if (ins_we) begin
            link_mem[n_idx] <= vhead_reg;
            key_mem[n_idx]  <= key_reg;
            ebkt_mem[n_idx] <= bucket_w;
        end
        link_rd_reg <= link_mem[ent_ra];
        key_rd_reg  <= key_mem[ent_ra];
        ebkt_rd_reg <= ebkt_mem[ent_ra];
    end

    // Walk registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_data.opcode;
            key_reg   <= s_data.key;
            hit_reg   <= '0;
            vhead_reg <= '0;
        end
        if (cmd.head_chk) begin
            cur_reg   <= heads_rd_reg;
            first_reg <= 1'b1;
            vhead_reg <= '0;
        end
        if (cmd.ent_chk) begin
            if (first_reg && !first_bad) begin
                vhead_reg <= cur_reg;
            end
            if (key_match) begin
                hit_reg <= cur_reg;
            end
            cur_reg   <= link_rd_reg;
            first_reg <= 1'b0;
        end
        res_reg <= res_next;
        if (cmd.out_load) begin
            m_data_reg <= res_reg;
        end
    end

    // Entry count, sweep address and output word valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.sweep) begin
                sweep_reg <= sweep_reg + IDX_W'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: hw/rtl/chtl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtl_ctrl
// Sequencer: head sweep after reset, hash, head read, chain walk, commit and
// hand-off of the result.
// ----------------------------------------------------------------------------
module chtl_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  chtl_pkg::chtl_stat_t stat,
    output chtl_pkg::chtl_cmd_t  cmd
);
    import chtl_pkg::*;

    chtl_state_t state_reg, state_next;
    logic        accept;

    assign accept = s_valid && (state_reg == ST_IDLE);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (stat.sweep_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = stat.in_clear ? ST_COMMIT : ST_HASH;
                end
            end
            ST_HASH: begin
                if (stat.hash_done) begin
                    state_next = ST_HEAD_RD;
                end
            end
            ST_HEAD_RD:  state_next = ST_HEAD_CHK;
            ST_HEAD_CHK: state_next = stat.head_empty ? ST_COMMIT : ST_ENT_CHK;
            ST_ENT_CHK: begin
                if (stat.walk_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: state_next = ST_RESP;
            ST_RESP: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd          = '0;
        s_ready      = 1'b0;
        case (state_reg)
            ST_INIT:     cmd.sweep = 1'b1;
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = accept;
            end
            ST_HEAD_CHK: cmd.head_chk = !stat.head_empty;
            ST_ENT_CHK:  cmd.ent_chk  = 1'b1;
            ST_COMMIT:   cmd.commit   = 1'b1;
            ST_RESP:     cmd.out_load = stat.out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
